// File: src/bba_pkg.sv
// Shared constants, types and helpers for the block bitmap allocator.
`default_nettype none
package bba_pkg;

	localparam int unsigned NUM_BLOCKS = 8192;
	localparam int unsigned IDX_W      = 13;
	localparam int unsigned WORD_W     = 64;
	localparam int unsigned NUM_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int unsigned WORD_AW    = $clog2(NUM_WORDS);
	localparam int unsigned BIT_AW     = $clog2(WORD_W);
	localparam int unsigned BLK_AW     = WORD_AW + BIT_AW;
	localparam int unsigned CNT_W      = $clog2(NUM_WORDS + 1);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic load;
		logic cnt_clr;
		logic cnt_inc;
		logic clr_wr;
		logic free_rd;
		logic scan_rd;
		logic free_wr;
		logic alloc_wr;
		logic res_free;
		logic res_alloc;
		logic res_full;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic issued_all;
		logic s1_vld;
		logic s1_last;
		logic hit;
	} sts_t;

	// Blocks that always count as used: the first block and the last three.
	function automatic logic [WORD_W-1:0] rsv_mask(input logic [WORD_AW-1:0] waddr);
		logic [WORD_W-1:0] m;
		logic [31:0]       b;
		m = '0;
		for (int i = 0; i < int'(WORD_W); i++) begin
			b = 32'({waddr, BIT_AW'(i)});
			m[i] = (b == 32'd0) || ((b + 32'd3) >= 32'(NUM_BLOCKS));
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// File: src/bba_dp.sv
// Datapath: bitmap memory, word counter, first-free search and result registers.
`default_nettype none
module bba_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bba_pkg::cmd_t               cmd,
	output bba_pkg::sts_t                    sts,
	input  wire logic [bba_pkg::IDX_W-1:0]   block_index,
	output logic                             status,
	output logic [bba_pkg::IDX_W-1:0]        block_number
);
	import bba_pkg::*;

	logic [WORD_W-1:0]  mem [NUM_WORDS];
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [WORD_W-1:0]  rd_data_s1;
	logic [WORD_AW-1:0] addr_s1;
	logic               vld_s1;
	logic               last_s1;
	logic               status_q;
	logic [IDX_W-1:0]   block_number_q;

	logic [31:0]        idx32;
	logic               free_ok;
	logic [WORD_AW-1:0] idx_word;
	logic [BIT_AW-1:0]  idx_bit;
	logic [WORD_W-1:0]  used;
	logic               any_free;
	logic [BIT_AW-1:0]  hit_bit;
	logic [BLK_AW-1:0]  hit_blk;
	logic               rd_en;
	logic [WORD_AW-1:0] rd_addr;
	logic               wr_en;
	logic [WORD_AW-1:0] wr_addr;
	logic [WORD_W-1:0]  wr_data;

	assign idx32    = 32'(idx_q);
	assign free_ok  = (idx32 != 32'd0) && ((idx32 + 32'd3) < 32'(NUM_BLOCKS));
	assign idx_word = idx32[BLK_AW-1:BIT_AW];
	assign idx_bit  = idx32[BIT_AW-1:0];

	assign used = rd_data_s1 | rsv_mask(addr_s1);

	always_comb begin
		any_free = 1'b0;
		hit_bit  = '0;
		for (int i = int'(WORD_W) - 1; i >= 0; i--) begin
			if (!used[i]) begin
				any_free = 1'b1;
				hit_bit  = BIT_AW'(i);
			end
		end
	end

	assign hit_blk = {addr_s1, hit_bit};

	assign sts.cnt_last   = (cnt_q == CNT_W'(NUM_WORDS - 1));
	assign sts.issued_all = (cnt_q == CNT_W'(NUM_WORDS));
	assign sts.s1_vld     = vld_s1;
	assign sts.s1_last    = last_s1;
	assign sts.hit        = vld_s1 && any_free;

	assign rd_en   = cmd.free_rd || cmd.scan_rd;
	assign rd_addr = cmd.free_rd ? idx_word : cnt_q[WORD_AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[WORD_AW-1:0];
		wr_data = '0;
		priority if (cmd.clr_wr) begin
			wr_en   = 1'b1;
		end else if (cmd.free_wr) begin
			wr_en   = free_ok;
			wr_addr = idx_word;
			wr_data = rd_data_s1 & ~(WORD_W'(1) << idx_bit);
		end else if (cmd.alloc_wr) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1;
			wr_data = rd_data_s1 | (WORD_W'(1) << hit_bit);
		end else begin
			wr_en   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			vld_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= block_index;
		end
		if (cmd.scan_rd) begin
			addr_s1 <= cnt_q[WORD_AW-1:0];
			last_s1 <= sts.cnt_last;
		end
		if (cmd.res_free) begin
			status_q       <= STATUS_OK;
			block_number_q <= '0;
		end else if (cmd.res_alloc) begin
			status_q       <= STATUS_OK;
			block_number_q <= IDX_W'(hit_blk);
		end else if (cmd.res_full) begin
			status_q       <= STATUS_FULL;
			block_number_q <= '0;
		end
	end

	assign status       = status_q;
	assign block_number = block_number_q;

endmodule
`default_nettype wire

// File: src/bba_ctrl.sv
// Controller: clearing pass, free read-modify-write and allocate word scan.
`default_nettype none
module bba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          func,
	input  wire bba_pkg::sts_t sts,
	output bba_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import bba_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_SCAN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   done_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load    = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = (func == FUNC_FREE) ? ST_FREE_RD : ST_SCAN;
				end
			end
			ST_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_d     = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				cmd.free_wr  = 1'b1;
				cmd.res_free = 1'b1;
				done_d       = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_rd = !sts.issued_all && !sts.hit;
				cmd.cnt_inc = cmd.scan_rd;
				if (sts.hit) begin
					cmd.alloc_wr  = 1'b1;
					cmd.res_alloc = 1'b1;
					done_d        = 1'b1;
					state_d       = ST_IDLE;
				end else if (sts.s1_vld && sts.s1_last) begin
					cmd.res_full = 1'b1;
					done_d       = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

// File: src/block_bitmap_allocator_top.sv
// Top level of the block bitmap allocator: controller plus bitmap datapath.
// Free: start loads the index, FREE_RD reads its word and FREE_WR clears the bit and
// registers the result; done rises as busy drops, so the next start can be taken then.
// Allocate: the bitmap is scanned one 64-block memory word per cycle until the first
// word with a free block, whose lowest free block is taken; FULL is returned otherwise.
// Reset clears all NUM_WORDS map words in one pass, one word per cycle, busy high.
// Results are strobed by done for one cycle; the receiver cannot stall.
`default_nettype none
module block_bitmap_allocator_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      func,
	input  wire logic [bba_pkg::IDX_W-1:0] block_index,
	output logic                           done,
	output logic                           status,
	output logic [bba_pkg::IDX_W-1:0]      block_number
);
	import bba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bba_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.block_index  (block_index),
		.status       (status),
		.block_number (block_number)
	);

endmodule
`default_nettype wire
